@@ rtl/dzf_pkg.sv @@
// shared constants, types and state codes for the dead-zone follow core
package dzf_pkg;

   localparam int COORD_BITS = 24;
   localparam int SIZE_BITS  = 23;
   localparam int FRAC_BITS  = 16;
   localparam int WIDE_BITS  = 48;
   localparam int SQ_BITS    = 50;
   localparam int ROOT_BITS  = 25;
   localparam int MUL_BITS   = 48;

   localparam logic [2:0] REG_VIEW_WIDTH  = 3'd0;
   localparam logic [2:0] REG_VIEW_HEIGHT = 3'd1;
   localparam logic [2:0] REG_HORIZ_FRAC  = 3'd2;
   localparam logic [2:0] REG_VERT_FRAC   = 3'd3;
   localparam logic [2:0] REG_MAX_STEP    = 3'd4;

   localparam logic signed [WIDE_BITS-1:0] COORD_MAX_W = 48'sd8388607;
   localparam logic signed [WIDE_BITS-1:0] COORD_MIN_W = -48'sd8388608;
   localparam logic [SQ_BITS-1:0] ONE_SQ = 50'd65536;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_MARG  = 9'b000000010,
      ST_GOAL  = 9'b000000100,
      ST_SQUARE = 9'b000001000,
      ST_DECIDE = 9'b000010000,
      ST_ROOT  = 9'b000100000,
      ST_SCALE = 9'b001000000,
      ST_APPLY = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   function automatic logic signed [WIDE_BITS-1:0] sat_coord(
         input logic signed [WIDE_BITS-1:0] v);
      logic signed [WIDE_BITS-1:0] r;
      r = v;
      if (v > COORD_MAX_W) r = COORD_MAX_W;
      else if (v < COORD_MIN_W) r = COORD_MIN_W;
      return r;
   endfunction

endpackage

@@ rtl/dzf_serial_mul.sv @@
// shift-and-add multiplier, one multiplier bit per cycle
module dzf_serial_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [dzf_pkg::COORD_BITS-1:0] a,
   input  logic [dzf_pkg::COORD_BITS-1:0] b,
   output logic                         done,
   output logic [dzf_pkg::MUL_BITS-1:0] product
);
   logic [dzf_pkg::MUL_BITS-1:0]   acc_ff, acc_in;
   logic [dzf_pkg::MUL_BITS-1:0]   mcand_ff, mcand_in;
   logic [dzf_pkg::COORD_BITS-1:0] mplier_ff, mplier_in;
   logic [4:0]                     cnt_ff, cnt_in;
   logic                           run_ff, run_in;
   logic                           done_ff, done_in;

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      run_in    = run_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = {{(dzf_pkg::MUL_BITS-dzf_pkg::COORD_BITS){1'b0}}, a};
         mplier_in = b;
         cnt_in    = 5'(dzf_pkg::COORD_BITS - 1);
         run_in    = 1'b1;
      end else if (run_ff) begin
         if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff - 5'd1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

`ifndef ASSERT_OFF
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("mul done held");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |=> run_ff) else $error("mul did not start");
   a_done_after_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff)) else $error("mul done without run");
`endif
endmodule

@@ rtl/deadzone_follow_rate_limited_core.sv @@
// dead-zone camera follow with speed limit, top level
//  channel   dir  fields
//  req_      in   tdata: target_x[23:0], target_y[47:24]; tuser: target_present
//  rsp_      out  tdata: new_center_x[23:0], new_center_y[47:24]; tuser: moved
//  csr_      in   apb registers at byte address 4*i
// one request at a time; without a target no product is formed. with a target the
// products run on the serial multiplier whether the centre stays or jumps to the
// goal, and a limited step adds the root and the two 48-step restoring divisions.
// reset zeroes the centre and reloads the register defaults.
// a stalled response holds; the next request is taken once it is delivered.
module deadzone_follow_rate_limited_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // target_x, target_y
   input  logic        req_tuser,  // target_present
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // new_center_x, new_center_y
   output logic        rsp_tuser,  // moved
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int W = dzf_pkg::WIDE_BITS;

   dzf_pkg::state_type state_ff, state_in;

   logic [22:0] vw_ff, vh_ff, step_ff;
   logic [15:0] hf_ff, vf_ff;
   logic signed [23:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [23:0] ox_ff, ox_in, oy_ff, oy_in;
   logic signed [23:0] tx_ff, tx_in, ty_ff, ty_in;
   logic signed [W-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [W-1:0] mx_ff, mx_in, my_ff, my_in;
   logic [dzf_pkg::SQ_BITS-1:0] s_ff, s_in;
   logic [2:0] sub_ff, sub_in;
   logic pres_ff, pres_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic rsp_user_ff, rsp_user_in;

   // sqrt regs
   logic [dzf_pkg::SQ_BITS-1:0] rn_ff, rn_in;
   logic [dzf_pkg::SQ_BITS-1:0] rr_ff, rr_in;
   logic [dzf_pkg::SQ_BITS-1:0] rb_ff, rb_in;
   // divider regs
   logic [W-1:0] dq_ff, dq_in;
   logic [W:0]   drem_ff, drem_in;
   logic [5:0]   dcnt_ff, dcnt_in;
   logic [W-1:0] num_ff, num_in;

   // multiplier
   logic mstart;
   logic [23:0] ma, mb;
   logic mdone;
   logic [W-1:0] mprod;

   dzf_serial_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mstart),
      .a      (ma),
      .b      (mb),
      .done   (mdone),
      .product(mprod)
   );

   logic cfg_wr;
   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_paddr[4:2])
         dzf_pkg::REG_VIEW_WIDTH:  csr_prdata = {9'd0, vw_ff};
         dzf_pkg::REG_VIEW_HEIGHT: csr_prdata = {9'd0, vh_ff};
         dzf_pkg::REG_HORIZ_FRAC:  csr_prdata = {16'd0, hf_ff};
         dzf_pkg::REG_VERT_FRAC:   csr_prdata = {16'd0, vf_ff};
         dzf_pkg::REG_MAX_STEP:    csr_prdata = {9'd0, step_ff};
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vw_ff   <= 23'd163840;
         vh_ff   <= 23'd122880;
         hf_ff   <= 16'd13107;
         vf_ff   <= 16'd13107;
         step_ff <= 23'd1280;
      end else if (cfg_wr && csr_paddr[1:0] == 2'd0) begin
         unique case (csr_paddr[4:2])
            dzf_pkg::REG_VIEW_WIDTH:  vw_ff   <= csr_pwdata[22:0];
            dzf_pkg::REG_VIEW_HEIGHT: vh_ff   <= csr_pwdata[22:0];
            dzf_pkg::REG_HORIZ_FRAC:  hf_ff   <= csr_pwdata[15:0];
            dzf_pkg::REG_VERT_FRAC:   vf_ff   <= csr_pwdata[15:0];
            dzf_pkg::REG_MAX_STEP:    step_ff <= csr_pwdata[22:0];
            default: ;
         endcase
      end
   end

   // axis goal, one axis per cycle in goal state
   logic signed [W-1:0] g_c, g_t, g_half, g_marg, g_res;
   logic [W-1:0] adx, ady;
   logic signed [W-1:0] dxw, dyw;
   logic sel_y;
   assign sel_y  = sub_ff[0];
   assign g_c    = sel_y ? W'(cy_ff) : W'(cx_ff);
   assign g_t    = sel_y ? W'(ty_ff) : W'(tx_ff);
   assign g_half = sel_y ? W'({1'b0, vh_ff[22:1]}) : W'({1'b0, vw_ff[22:1]});
   assign g_marg = sel_y ? $signed(my_ff) : $signed(mx_ff);

   always_comb begin
      priority if (g_t < g_c - g_half + g_marg)
         g_res = dzf_pkg::sat_coord(g_t - g_marg + g_half);
      else if (g_t > g_c + g_half - g_marg)
         g_res = dzf_pkg::sat_coord(g_t + g_marg - g_half);
      else
         g_res = g_c;
   end

   assign dxw = gx_ff - W'(cx_ff);
   assign dyw = gy_ff - W'(cy_ff);
   assign adx = dxw[W-1] ? W'(-dxw) : W'(dxw);
   assign ady = dyw[W-1] ? W'(-dyw) : W'(dyw);

   logic [dzf_pkg::SQ_BITS-1:0] r_try;
   assign r_try = rr_ff + rb_ff;

   logic [W:0] drem_sh;
   assign drem_sh = {drem_ff[W-1:0], num_ff[W-1]};

   logic signed [W-1:0] nx_w;
   logic signed [W-1:0] sel_d;
   assign sel_d = sub_ff[0] ? dyw : dxw;
   assign nx_w = dzf_pkg::sat_coord((sub_ff[0] ? W'(cy_ff) : W'(cx_ff))
                 + (sel_d[W-1] ? -$signed(dq_ff) : $signed(dq_ff)));

   always_comb begin
      state_in     = state_ff;
      cx_in = cx_ff; cy_in = cy_ff; ox_in = ox_ff; oy_in = oy_ff;
      tx_in = tx_ff; ty_in = ty_ff; gx_in = gx_ff; gy_in = gy_ff;
      mx_in = mx_ff; my_in = my_ff; s_in = s_ff; sub_in = sub_ff;
      pres_in = pres_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rn_in = rn_ff; rr_in = rr_ff; rb_in = rb_ff;
      dq_in = dq_ff; drem_in = drem_ff; dcnt_in = dcnt_ff; num_in = num_ff;
      mstart = 1'b0;
      ma = '0; mb = '0;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         dzf_pkg::ST_IDLE: begin
            if (req_tvalid && !rsp_valid_ff) begin
               tx_in   = $signed(req_tdata[23:0]);
               ty_in   = $signed(req_tdata[47:24]);
               pres_in = req_tuser;
               ox_in   = cx_ff;
               oy_in   = cy_ff;
               sub_in  = '0;
               if (req_tuser) begin
                  mstart = 1'b1;
                  ma = {1'b0, vw_ff}; mb = {8'd0, hf_ff};
                  state_in = dzf_pkg::ST_MARG;
               end else begin
                  state_in = dzf_pkg::ST_OUT;
               end
            end
         end
         dzf_pkg::ST_MARG: begin
            if (mdone) begin
               if (!sub_ff[0]) begin
                  mx_in = mprod >> 16;
                  sub_in = 3'd1;
                  mstart = 1'b1;
                  ma = {1'b0, vh_ff}; mb = {8'd0, vf_ff};
               end else begin
                  my_in = mprod >> 16;
                  sub_in = 3'd0;
                  state_in = dzf_pkg::ST_GOAL;
               end
            end
         end
         dzf_pkg::ST_GOAL: begin
            if (!sub_ff[0]) begin
               gx_in = g_res;
               sub_in = 3'd1;
            end else begin
               gy_in = g_res;
               sub_in = 3'd0;
               state_in = dzf_pkg::ST_SQUARE;
               mstart = 1'b1;
               ma = adx[23:0]; mb = adx[23:0];
            end
         end
         dzf_pkg::ST_SQUARE: begin
            if (mdone) begin
               unique case (sub_ff[1:0])
                  2'd0: begin
                     s_in = dzf_pkg::SQ_BITS'(mprod);
                     sub_in = 3'd1;
                     mstart = 1'b1;
                     ma = ady[23:0]; mb = ady[23:0];
                  end
                  2'd1: begin
                     s_in = s_ff + dzf_pkg::SQ_BITS'(mprod);
                     sub_in = 3'd2;
                     mstart = 1'b1;
                     ma = {1'b0, step_ff}; mb = {1'b0, step_ff};
                  end
                  default: begin
                     mx_in = mprod;
                     sub_in = 3'd0;
                     state_in = dzf_pkg::ST_DECIDE;
                  end
               endcase
            end
         end
         dzf_pkg::ST_DECIDE: begin
            if (s_ff <= dzf_pkg::ONE_SQ) begin
               state_in = dzf_pkg::ST_OUT;
            end else if (dzf_pkg::SQ_BITS'(mx_ff) >= s_ff) begin
               cx_in = gx_ff[23:0];
               cy_in = gy_ff[23:0];
               state_in = dzf_pkg::ST_OUT;
            end else begin
               rn_in = s_ff;
               rr_in = '0;
               rb_in = dzf_pkg::SQ_BITS'(1) << (dzf_pkg::SQ_BITS - 2);
               state_in = dzf_pkg::ST_ROOT;
            end
         end
         dzf_pkg::ST_ROOT: begin
            if (rb_ff == '0) begin
               sub_in = 3'd0;
               mstart = 1'b1;
               ma = adx[23:0]; mb = {1'b0, step_ff};
               state_in = dzf_pkg::ST_SCALE;
            end else begin
               if (rn_ff >= r_try) begin
                  rn_in = rn_ff - r_try;
                  rr_in = (rr_ff >> 1) + rb_ff;
               end else begin
                  rr_in = rr_ff >> 1;
               end
               rb_in = rb_ff >> 2;
            end
         end
         dzf_pkg::ST_SCALE: begin
            if (mdone) begin
               num_in  = mprod;
               drem_in = '0;
               dq_in   = '0;
               dcnt_in = 6'(W);
               state_in = dzf_pkg::ST_APPLY;
            end
         end
         dzf_pkg::ST_APPLY: begin
            if (dcnt_ff != '0) begin
               num_in = num_ff << 1;
               dcnt_in = dcnt_ff - 6'd1;
               if (drem_sh >= (W+1)'(rr_ff)) begin
                  drem_in = drem_sh - (W+1)'(rr_ff);
                  dq_in = {dq_ff[W-2:0], 1'b1};
               end else begin
                  drem_in = drem_sh;
                  dq_in = {dq_ff[W-2:0], 1'b0};
               end
            end else if (!sub_ff[0]) begin
               cx_in = nx_w[23:0];
               sub_in = 3'd1;
               mstart = 1'b1;
               ma = ady[23:0]; mb = {1'b0, step_ff};
               state_in = dzf_pkg::ST_SCALE;
            end else begin
               cy_in = nx_w[23:0];
               sub_in = 3'd0;
               state_in = dzf_pkg::ST_OUT;
            end
         end
         dzf_pkg::ST_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = {cy_ff, cx_ff};
            rsp_user_in  = (cx_ff != ox_ff) || (cy_ff != oy_ff);
            state_in = dzf_pkg::ST_IDLE;
         end
         default: state_in = dzf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dzf_pkg::ST_IDLE;
         cx_ff        <= '0;
         cy_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         sub_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         rsp_valid_ff <= rsp_valid_in;
         sub_ff       <= sub_in;
      end
      ox_ff <= ox_in; oy_ff <= oy_in; tx_ff <= tx_in; ty_ff <= ty_in;
      gx_ff <= gx_in; gy_ff <= gy_in; mx_ff <= mx_in; my_ff <= my_in;
      s_ff <= s_in; pres_ff <= pres_in;
      rsp_data_ff <= rsp_data_in; rsp_user_ff <= rsp_user_in;
      rn_ff <= rn_in; rr_ff <= rr_in; rb_ff <= rb_in;
      dq_ff <= dq_in; drem_ff <= drem_in; dcnt_ff <= dcnt_in; num_ff <= num_in;
   end

   assign req_tready = (state_ff == dzf_pkg::ST_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef ASSERT_OFF
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != dzf_pkg::ST_IDLE) |-> !req_tready) else $error("ready while busy");
   a_absent_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dzf_pkg::ST_OUT && !pres_ff) |-> (cx_ff == ox_ff && cy_ff == oy_ff))
      else $error("center moved without target");
   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dzf_pkg::ST_OUT) |=> rsp_valid_ff) else $error("response lost");
`endif
endmodule

@@ tb/tb_deadzone_follow_rate_limited_core.sv @@
// testbench for the dead-zone follow core: random and directed targets checked against a predictor
`timescale 1ns / 1ps

module tb_deadzone_follow_rate_limited_core;

   typedef struct packed {
      logic signed [23:0] cy;
      logic signed [23:0] cx;
      logic moved;
   } centre_type;

   localparam logic [2:0] REG_SPARE = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0, req_tuser = 1'b0;
   logic req_tready;
   logic [47:0] req_tdata = '0;
   logic rsp_tvalid, rsp_tuser;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [4:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   deadzone_follow_rate_limited_core i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   longint m_width, m_height, m_hfrac, m_vfrac, m_step, m_cx, m_cy;
   centre_type centre_q[$];
   int errors = 0, n_sent = 0, n_got = 0, n_moved = 0;
   int send_idle = 0, recv_idle = 0;
   bit hold_off = 0;

   function automatic longint clamp24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   function automatic longint zone_goal(longint c, longint t, longint sz, longint fr);
      longint half, margin;
      half = sz >>> 1;
      margin = (sz * fr) >>> 16;
      if (t < c - half + margin) return clamp24(t - margin + half);
      if (t > c + half - margin) return clamp24(t + margin - half);
      return c;
   endfunction

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned root, bt;
      root = 0;
      bt = 64'd1 << 62;
      while (bt > n) bt >>= 2;
      while (bt != 0) begin
         if (n >= root + bt) begin
            n -= root + bt;
            root = (root >> 1) + bt;
         end else begin
            root >>= 1;
         end
         bt >>= 2;
      end
      return root;
   endfunction

   function automatic longint step_part(longint d, longint st, longint root_len);
      longint unsigned mag, q;
      mag = (d < 0) ? -d : d;
      q = (mag * st) / root_len;
      return (d < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic centre_type follow_target(logic present, logic [23:0] tx,
                                                logic [23:0] ty);
      centre_type r;
      longint gx, gy, dx, dy, ox, oy, root_len;
      longint unsigned s;
      ox = m_cx;
      oy = m_cy;
      if (present) begin
         gx = zone_goal(m_cx, longint'($signed(tx)), m_width, m_hfrac);
         gy = zone_goal(m_cy, longint'($signed(ty)), m_height, m_vfrac);
         dx = gx - m_cx;
         dy = gy - m_cy;
         s = dx * dx + dy * dy;
         if (s > 65536) begin
            if (longint'(m_step * m_step) >= s) begin
               m_cx = gx;
               m_cy = gy;
            end else begin
               root_len = int_sqrt(s);
               m_cx = clamp24(m_cx + step_part(dx, m_step, root_len));
               m_cy = clamp24(m_cy + step_part(dy, m_step, root_len));
            end
         end
      end
      r.cx = m_cx[23:0];
      r.cy = m_cy[23:0];
      r.moved = (m_cx != ox) || (m_cy != oy);
      return r;
   endfunction

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         dzf_pkg::REG_VIEW_WIDTH:  m_width = val & 32'h7FFFFF;
         dzf_pkg::REG_VIEW_HEIGHT: m_height = val & 32'h7FFFFF;
         dzf_pkg::REG_HORIZ_FRAC:  m_hfrac = val & 32'hFFFF;
         dzf_pkg::REG_VERT_FRAC:   m_vfrac = val & 32'hFFFF;
         dzf_pkg::REG_MAX_STEP:    m_step = val & 32'h7FFFFF;
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_view(int w, int h, int hf, int vf, int st);
      csr_write(dzf_pkg::REG_VIEW_WIDTH, w);
      csr_write(dzf_pkg::REG_VIEW_HEIGHT, h);
      csr_write(dzf_pkg::REG_HORIZ_FRAC, hf);
      csr_write(dzf_pkg::REG_VERT_FRAC, vf);
      csr_write(dzf_pkg::REG_MAX_STEP, st);
   endtask

   task automatic send_target(logic present, logic [23:0] tx, logic [23:0] ty);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= present;
      req_tdata <= {ty, tx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      centre_q.push_back(follow_target(present, tx, ty));
      n_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (centre_q.size() != 0) @(negedge clock);
      repeat (250) @(negedge clock);
   endtask

   function automatic logic [23:0] near_edge(longint c, longint sz, longint fr);
      longint e;
      e = c + (($urandom_range(1)) ? 1 : -1) *
          ((sz >>> 1) - ((sz * fr) >>> 16) + $signed($urandom_range(2000)) - 1000);
      return 24'(clamp24(e));
   endfunction

   task automatic random_targets(int n);
      logic [23:0] tx, ty;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: begin
               tx = 24'($urandom);
               ty = 24'($urandom);
            end
            1: begin
               tx = 24'(clamp24(m_cx + $signed($urandom_range(8000)) - 4000));
               ty = 24'(clamp24(m_cy + $signed($urandom_range(8000)) - 4000));
            end
            default: begin
               tx = near_edge(m_cx, m_width, m_hfrac);
               ty = near_edge(m_cy, m_height, m_vfrac);
            end
         endcase
         send_target($urandom_range(9) != 0, tx, ty);
      end
   endtask

   task automatic test_directed();
      set_view(163840, 122880, 13107, 13107, 1280);
      send_target(1'b0, 24'h7FFFFF, 24'h800000);
      send_target(1'b1, 24'h000000, 24'h000000);
      send_target(1'b1, 24'h7FFFFF, 24'h7FFFFF);
      send_target(1'b1, 24'h800000, 24'h800000);
      send_target(1'b1, 24'hFFFFFF, 24'h000001);
      drain();
      set_view(8388607, 8388607, 0, 0, 8388607);
      send_target(1'b1, 24'h800000, 24'h7FFFFF);
      send_target(1'b1, 24'h7FFFFF, 24'h800000);
      drain();
      set_view(0, 0, 65535, 32768, 1);
      send_target(1'b1, 24'h000300, 24'hFFFD00);
      send_target(1'b1, 24'h000100, 24'h000000);
      send_target(1'b0, 24'h555555, 24'hAAAAAA);
      drain();
      set_view(1000, 800, 40000, 32768, 0);
      send_target(1'b1, 24'h123456, 24'h876543);
      drain();
      set_view(256, 256, 65535, 65535, 256);
      send_target(1'b1, 24'h400000, 24'hC00000);
      send_target(1'b1, 24'h000080, 24'h000080);
      drain();
      csr_write(REG_SPARE, 32'hFFFFFFFF);
      set_view(32'hFFFFFFFF, 163840, 32'h12345, 13107, 32'hFF800500);
      send_target(1'b1, 24'h3FFFFF, 24'hC00001);
      drain();
   endtask

   task automatic test_random_settings();
      set_view(163840, 122880, 13107, 13107, 1280);
      random_targets(100);
      drain();
      set_view($urandom_range(100000, 256), $urandom_range(100000, 256),
               $urandom_range(32768), $urandom_range(32768), $urandom_range(20000, 1));
      random_targets(100);
      drain();
   endtask

   task automatic test_backpressure();
      hold_off = 1;
      random_targets(5);
      drain();
      random_targets(10);
      drain();
   endtask

   task automatic test_no_idling();
      set_view(8388607, 4000, 32768, 100, 8388607);
      random_targets(100);
      drain();
      set_view(20000, 30000, 0, 60000, 50);
      random_targets(150);
      drain();
   endtask

   // response side: stall pattern and compare
   always @(negedge clock) begin
      if (hold_off) begin
         rsp_tready <= 1'b0;
         repeat (600) @(negedge clock);
         hold_off = 0;
      end else begin
         rsp_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
      end
   end

   always @(posedge clock) begin
      centre_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_got++;
         if (centre_q.size() == 0) begin
            $error("unexpected request result %h", rsp_tdata);
            errors++;
         end else begin
            want = centre_q.pop_front();
            n_moved += rsp_tuser;
            if (rsp_tdata[23:0] !== want.cx) begin
               $error("new_center_x exp %h got %h", want.cx, rsp_tdata[23:0]);
               errors++;
            end
            if (rsp_tdata[47:24] !== want.cy) begin
               $error("new_center_y exp %h got %h", want.cy, rsp_tdata[47:24]);
               errors++;
            end
            if (rsp_tuser !== want.moved) begin
               $error("moved exp %b got %b", want.moved, rsp_tuser);
               errors++;
            end
         end
      end
   end

   initial begin
      m_width = 163840;
      m_height = 122880;
      m_hfrac = 13107;
      m_vfrac = 13107;
      m_step = 1280;
      m_cx = 0;
      m_cy = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle = 7;
      recv_idle = 88;
      test_directed();
      test_random_settings();
      send_idle = 88;
      recv_idle = 7;
      test_backpressure();
      test_random_settings();
      send_idle = 0;
      recv_idle = 0;
      test_no_idling();
      if (centre_q.size() != 0) errors++;
      $display("%0d requests sent, %0d results checked, %0d moves, several view settings",
               n_sent, n_got, n_moved);
      if (errors == 0) begin
         $display("** deadzone_follow_rate_limited_core: PASSED **");
      end else begin
         $display("** deadzone_follow_rate_limited_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("** deadzone_follow_rate_limited_core: FAILED **");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/dzf_pkg.sv
rtl/dzf_serial_mul.sv
rtl/deadzone_follow_rate_limited_core.sv
tb/tb_deadzone_follow_rate_limited_core.sv
